/* rtl/ccg_pkg.sv */
// Shared constants, codes and types of the coulomb counting charge gauge.
package ccg_pkg;

  localparam int unsigned LevelW   = 10;
  localparam int unsigned MahW     = 20;
  localparam int unsigned UsedW    = 24;
  localparam int unsigned PctW     = 11;
  localparam int unsigned ThrW     = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned QuotW    = 10;
  localparam int unsigned NumW     = MahW + QuotW;
  localparam int unsigned RiseW    = PctW + 1;
  localparam int unsigned SubW     = UsedW + 2;

  localparam int unsigned FullScale = 1000;
  localparam int unsigned CapTol    = 100;
  localparam int unsigned ThrReset  = 50;
  localparam int          PctAbsent = -10;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_RESTART = 2'd1,
    OP_CAPCHG  = 2'd2,
    OP_SPARE   = 2'd3
  } ccg_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAPACITY   = 3'd0,
    CFG_THRESHOLD  = 3'd1,
    CFG_RST_VALID  = 3'd2,
    CFG_RST_REMAIN = 3'd3,
    CFG_RST_CAP    = 3'd4,
    CFG_RST_PCT    = 3'd5
  } ccg_cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SUB,
    S_MUL,
    S_DIV,
    S_EMIT
  } ccg_state_e;

  typedef struct packed {
    logic [MahW-1:0]        capacity_mah;
    logic [ThrW-1:0]        charge_threshold;
    logic                   restore_valid;
    logic [MahW-1:0]        restore_remaining;
    logic [MahW-1:0]        restore_capacity;
    logic signed [PctW-1:0] restore_percent;
  } ccg_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ccg_div_stat_t;

endpackage

/* rtl/coulomb_count_charge_gauge.sv */
// Top level of the coulomb counting charge gauge with its sequencer and state.
//
// Input words arrive on in_valid_i / in_stall_o and carry an opcode, the
// controller level and its cumulative consumed charge. A sample word gives
// one result word on out_valid_o / out_stall_i; a restart or capacity-change
// word only updates the internal state and gives no result.
// The block takes one word at a time and holds in_stall_o high until its work
// is done. A restart or capacity-change word is handled in the decision step,
// after which the sequencer returns to idle; a sample ending early (zero
// capacity, reset to full) goes from the decision step to the emit step, which
// loads the result register. A counted sample passes through the decision,
// subtraction, scaling multiply, bit-serial divider and emit steps. The result
// sits in an output register, so a new word is accepted while the previous
// result still waits; if that result is still stalled when the next one is
// ready, the sequencer waits in its emit step and the input stays stalled. A
// stalled result word holds its value. Reset empties the output register,
// returns the sequencer to idle and loads the documented reset values into the
// configuration and gauge state. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i, one register per cycle; the user must write it only
// while the block is idle, which the block itself does not enforce.
module coulomb_count_charge_gauge import ccg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          opcode_i,
  input  logic [LevelW-1:0]   level_permille_i,
  input  logic [UsedW-1:0]    used_mah_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LevelW-1:0]   percent_permille_o,
  output logic [MahW-1:0]     remaining_mah_o,
  output logic                did_reset_o,
  output logic                charge_seen_o
);

  ccg_cfg_t      cfg;
  ccg_div_stat_t div_stat;
  logic [QuotW-1:0] div_quot;

  ccg_state_e state_q, state_d;

  // Captured input word.
  logic [1:0]        op_q;
  logic [LevelW-1:0] level_q;
  logic [UsedW-1:0]  used_q;

  // Gauge state.
  logic [MahW-1:0]        remaining_q;
  logic [UsedW-1:0]       last_used_q;
  logic [MahW-1:0]        rec_cap_q;
  logic signed [PctW-1:0] start_pct_q;
  logic                   ready_q, start_pend_q, cap_pend_q;

  // Pending result and the output register.
  logic [LevelW-1:0] res_pct_q;
  logic [MahW-1:0]   res_rem_q;
  logic              res_reset_q, res_seen_q;
  logic              out_valid_q;
  logic [LevelW-1:0] out_pct_q;
  logic [MahW-1:0]   out_rem_q;
  logic              out_reset_q, out_seen_q;

  logic [NumW-1:0] prod;

  logic                   in_acc, out_free, div_start;
  logic                   cap_zero, cap_far, full_reset;
  logic signed [RiseW-1:0] rise;
  logic                   rise_big;
  logic signed [SubW-1:0] sub_val;
  logic [MahW-1:0]        sub_clamped;
  logic [LevelW-1:0]      level_sat;

  ccg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ccg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod),
    .den_i   (cfg.capacity_mah),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign level_sat = (level_permille_i > LevelW'(FullScale)) ? LevelW'(FullScale)
                                                             : level_permille_i;

  // Decision terms for a sample word.
  assign cap_zero = (cfg.capacity_mah == '0);
  assign cap_far  = ({1'b0, rec_cap_q} > ({1'b0, cfg.capacity_mah} + (MahW+1)'(CapTol))) ||
                    ({1'b0, cfg.capacity_mah} > ({1'b0, rec_cap_q} + (MahW+1)'(CapTol)));
  assign rise     = $signed({2'b00, level_q}) - RiseW'(start_pct_q);
  assign rise_big = rise > $signed({2'b00, cfg.charge_threshold});
  assign full_reset = cap_pend_q || (ready_q && (rec_cap_q != '0) && cap_far) || !ready_q ||
                      (start_pend_q && rise_big);

  // Remaining charge minus the rise in consumed charge, clamped to 0..capacity.
  assign sub_val = $signed({6'b0, remaining_q}) - $signed({2'b00, used_q}) +
                   $signed({2'b00, last_used_q});
  always_comb begin
    if (sub_val[SubW-1]) begin
      sub_clamped = '0;
    end else if (sub_val > $signed({6'b0, cfg.capacity_mah})) begin
      sub_clamped = cfg.capacity_mah;
    end else begin
      sub_clamped = sub_val[MahW-1:0];
    end
  end

  // The scaling multiply works on the freshly counted charge during the
  // multiply step, and the divider loads the product as it starts.
  assign prod = NumW'(remaining_q) * NumW'(FullScale);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (op_q != OP_SAMPLE) begin
          state_d = S_IDLE;
        end else if (cap_zero || full_reset) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_SUB;
        end
      end
      S_SUB:  state_d = S_MUL;
      S_MUL:  state_d = S_DIV;
      S_DIV: begin
        if (div_stat.done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    case (state_q)
      S_IDLE:  in_stall_o = 1'b0;
      S_MUL:   div_start  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Captured word needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= opcode_i;
      level_q <= level_sat;
      used_q  <= used_mah_i;
    end
  end

  // Gauge state and the pending result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q  <= '0;
      last_used_q  <= '0;
      rec_cap_q    <= '0;
      start_pct_q  <= PctW'(PctAbsent);
      ready_q      <= 1'b0;
      start_pend_q <= 1'b1;
      cap_pend_q   <= 1'b0;
      res_pct_q    <= '0;
      res_rem_q    <= '0;
      res_reset_q  <= 1'b0;
      res_seen_q   <= 1'b0;
    end else begin
      case (state_q)
        S_EVAL: begin
          case (op_q)
            OP_RESTART: begin
              remaining_q  <= cfg.restore_valid ? cfg.restore_remaining : '0;
              rec_cap_q    <= cfg.restore_valid ? cfg.restore_capacity : '0;
              ready_q      <= cfg.restore_valid;
              start_pct_q  <= cfg.restore_percent;
              last_used_q  <= '0;
              start_pend_q <= 1'b1;
              cap_pend_q   <= 1'b0;
            end
            OP_CAPCHG: cap_pend_q <= 1'b1;
            OP_SAMPLE: begin
              res_pct_q   <= level_q;
              res_reset_q <= 1'b0;
              res_seen_q  <= 1'b0;
              if (cap_zero) begin
                res_rem_q <= remaining_q;
              end else begin
                // The start-up record follows the level once the simple
                // reset causes have been ruled out.
                if (!cap_pend_q && !(ready_q && (rec_cap_q != '0) && cap_far) &&
                    ready_q && start_pend_q) begin
                  start_pct_q <= PctW'($signed({1'b0, level_q}));
                  if (!rise_big) start_pend_q <= 1'b0;
                end
                if (full_reset) begin
                  remaining_q  <= cfg.capacity_mah;
                  rec_cap_q    <= cfg.capacity_mah;
                  last_used_q  <= '0;
                  start_pend_q <= 1'b1;
                  cap_pend_q   <= 1'b0;
                  ready_q      <= 1'b1;
                  res_rem_q    <= cfg.capacity_mah;
                  res_reset_q  <= 1'b1;
                  res_seen_q   <= !cap_pend_q && !(ready_q && (rec_cap_q != '0) && cap_far) &&
                                  ready_q && start_pend_q && rise_big;
                end
              end
            end
            default: ;
          endcase
        end
        S_SUB: begin
          remaining_q <= sub_clamped;
          last_used_q <= used_q;
          res_rem_q   <= sub_clamped;
        end
        S_DIV: begin
          if (div_stat.done) res_pct_q <= div_quot;
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      out_pct_q   <= res_pct_q;
      out_rem_q   <= res_rem_q;
      out_reset_q <= res_reset_q;
      out_seen_q  <= res_seen_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign percent_permille_o = out_pct_q;
  assign remaining_mah_o    = out_rem_q;
  assign did_reset_o        = out_reset_q;
  assign charge_seen_o      = out_seen_q;

  // A level is never above full scale.
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (percent_permille_o <= LevelW'(FullScale)))
    else $error("result level above full scale");

  // Counted charge always lands inside the capacity.
  a_rem_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUB) |=> (remaining_q <= cfg.capacity_mah))
    else $error("remaining charge outside capacity");

  // Charging seen only comes with a reset to full.
  a_seen_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && charge_seen_o) |-> did_reset_o)
    else $error("charge seen without reset");

  // The divider is started once and then runs while the sequencer waits on it.
  a_div_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (div_stat.busy && state_q == S_DIV))
    else $error("divider not running after start");

endmodule

/* rtl/ccg_cfg.sv */
// Configuration register bank of the charge gauge.
module ccg_cfg import ccg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output ccg_cfg_t            cfg_o
);

  ccg_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity_mah      <= '0;
      cfg_q.charge_threshold  <= ThrW'(ThrReset);
      cfg_q.restore_valid     <= 1'b0;
      cfg_q.restore_remaining <= '0;
      cfg_q.restore_capacity  <= '0;
      cfg_q.restore_percent   <= PctW'(PctAbsent);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAPACITY:   cfg_q.capacity_mah      <= cfg_data_i[MahW-1:0];
        CFG_THRESHOLD:  cfg_q.charge_threshold  <= cfg_data_i[ThrW-1:0];
        CFG_RST_VALID:  cfg_q.restore_valid     <= cfg_data_i[0];
        CFG_RST_REMAIN: cfg_q.restore_remaining <= cfg_data_i[MahW-1:0];
        CFG_RST_CAP:    cfg_q.restore_capacity  <= cfg_data_i[MahW-1:0];
        CFG_RST_PCT:    cfg_q.restore_percent   <= cfg_data_i[PctW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/ccg_div.sv */
// Restoring divider producing one quotient bit per cycle.
module ccg_div import ccg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [MahW-1:0]  den_i,
  output ccg_div_stat_t    stat_o,
  output logic [QuotW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(QuotW + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [MahW-1:0] rem_q, den_q;
  logic [QuotW-1:0] low_q;
  logic [MahW+1:0] trial;
  logic            take;

  // The quotient is known to fit in QuotW bits, so the upper numerator bits
  // already form a partial remainder below the divisor.
  assign trial = {1'b0, rem_q, low_q[QuotW-1]} - {2'b00, den_q};
  assign take  = ~trial[MahW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(QuotW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[NumW-1:QuotW];
      low_q <= num_i[QuotW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= take ? trial[MahW-1:0] : {rem_q[MahW-2:0], low_q[QuotW-1]};
      low_q <= {low_q[QuotW-2:0], take};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = low_q;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the coulomb counting charge gauge: directed plan, then random phases.
module testbench;
  import ccg_pkg::*;

  localparam int unsigned DrainCycles  = 24;
  localparam int unsigned Phases       = 12;
  localparam int unsigned PhaseItems   = 120;
  localparam int unsigned SqueezePhase = 2;
  localparam int unsigned HoldOff      = 400;
  localparam int unsigned Limit        = 400000;
  localparam logic [CfgIdxW-1:0] IdxPastEnd = CfgIdxW'(int'(CFG_RST_PCT) + 1);
  localparam logic [CfgIdxW-1:0] IdxTop     = '1;

  typedef struct packed {
    logic [LevelW-1:0] pct;
    logic [MahW-1:0]   rem;
    logic              did_reset;
    logic              seen;
  } reading_t;

  typedef struct {
    bit                  is_reg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    ccg_op_e             op;
    logic [LevelW-1:0]   lvl;
    logic [UsedW-1:0]    used;
    bit                  typed;
    reading_t            want;
  } plan_row_t;

  typedef enum {FLOW, LIGHT, HALF, HEAVY} stall_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          opcode_i;
  logic [LevelW-1:0]   level_permille_i;
  logic [UsedW-1:0]    used_mah_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [LevelW-1:0]   percent_permille_o;
  logic [MahW-1:0]     remaining_mah_o;
  logic                did_reset_o;
  logic                charge_seen_o;

  // Hand-typed expectation that travels with the word on offer.
  bit       typed_i;
  reading_t typed_word;

  // Register mirror and gauge state of the predictor.
  logic [MahW-1:0]  reg_capacity, reg_rst_remain, reg_rst_cap;
  logic [ThrW-1:0]  reg_threshold;
  logic             reg_rst_valid;
  int               reg_rst_pct;
  logic [MahW-1:0]  est_remaining, est_rec_cap;
  logic [UsedW-1:0] est_last_used;
  int               est_start_lvl;
  bit               est_ready, est_start_check, est_cap_changed;

  reading_t    due_readings[$];
  plan_row_t   plan[$];
  int unsigned fail_cnt, words_in, readings_ok, refills, seen_cnt, writes_done, cycle_cnt;
  bit          squeeze_req, squeeze_done;

  coulomb_count_charge_gauge i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .opcode_i,
    .level_permille_i,
    .used_mah_i,
    .out_valid_o,
    .out_stall_i,
    .percent_permille_o,
    .remaining_mah_o,
    .did_reset_o,
    .charge_seen_o
  );

  always #5 clk_i = ~clk_i;

  function automatic void note_fault(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic reading_t rd(input int pct, input int rem, input bit rs, input bit sn);
    reading_t r;
    r.pct       = LevelW'(pct);
    r.rem       = MahW'(rem);
    r.did_reset = rs;
    r.seen      = sn;
    return r;
  endfunction

  function automatic void add_reg(input logic [CfgIdxW-1:0] idx, input int val);
    plan_row_t r;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = CfgDataW'(val);
    r.op     = OP_SAMPLE;
    r.lvl    = '0;
    r.used   = '0;
    r.typed  = 1'b0;
    r.want   = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_item(input ccg_op_e op, input int lvl, input int used,
                                   input bit typed = 1'b0, input reading_t want = '0);
    plan_row_t r;
    r.is_reg = 1'b0;
    r.idx    = '0;
    r.val    = '0;
    r.op     = op;
    r.lvl    = LevelW'(lvl);
    r.used   = UsedW'(used);
    r.typed  = typed;
    r.want   = want;
    plan.push_back(r);
  endfunction

  // The gauge jumps to a full battery and arms the start-up check again.
  function automatic reading_t refill_gauge(input logic [LevelW-1:0] lvl, input bit seen);
    est_remaining   = reg_capacity;
    est_rec_cap     = reg_capacity;
    est_last_used   = '0;
    est_start_check = 1'b1;
    est_cap_changed = 1'b0;
    est_ready       = 1'b1;
    return rd(int'(lvl), int'(reg_capacity), 1'b1, seen);
  endfunction

  // Advances the gauge by one word; returns 1 when the word yields a reading.
  function automatic bit count_coulombs(input ccg_op_e op, input logic [LevelW-1:0] lvl_in,
                                        input logic [UsedW-1:0] used, output reading_t w);
    logic [LevelW-1:0] lvl;
    int                cap_gap, rise;
    longint            left;
    w = '0;
    if (op == OP_RESTART) begin
      est_remaining   = reg_rst_valid ? reg_rst_remain : '0;
      est_rec_cap     = reg_rst_valid ? reg_rst_cap : '0;
      est_ready       = reg_rst_valid;
      est_start_lvl   = reg_rst_pct;
      est_last_used   = '0;
      est_start_check = 1'b1;
      est_cap_changed = 1'b0;
      return 1'b0;
    end
    if (op == OP_CAPCHG) begin
      est_cap_changed = 1'b1;
      return 1'b0;
    end
    if (op != OP_SAMPLE) begin
      return 1'b0;
    end
    lvl = (lvl_in > FullScale) ? LevelW'(FullScale) : lvl_in;
    // With no capacity the controller level passes straight through.
    if (reg_capacity == '0) begin
      w = rd(int'(lvl), int'(est_remaining), 1'b0, 1'b0);
      return 1'b1;
    end
    cap_gap = int'(est_rec_cap) - int'(reg_capacity);
    if (cap_gap < 0) begin
      cap_gap = -cap_gap;
    end
    if (est_cap_changed || !est_ready || (est_rec_cap != '0 && cap_gap > int'(CapTol))) begin
      w = refill_gauge(lvl, 1'b0);
      return 1'b1;
    end
    if (est_start_check) begin
      rise          = int'(lvl) - est_start_lvl;
      est_start_lvl = int'(lvl);
      if (rise > int'(reg_threshold)) begin
        w = refill_gauge(lvl, 1'b1);
        return 1'b1;
      end
      est_start_check = 1'b0;
    end
    left          = longint'(est_remaining) - (longint'(used) - longint'(est_last_used));
    est_last_used = used;
    if (left < 0) begin
      left = 0;
    end
    if (left > longint'(reg_capacity)) begin
      left = longint'(reg_capacity);
    end
    est_remaining = MahW'(left);
    w = rd(int'((longint'(est_remaining) * longint'(FullScale)) / longint'(reg_capacity)),
           int'(est_remaining), 1'b0, 1'b0);
    return 1'b1;
  endfunction

  // Watches both handshakes and the register port at every rising edge.
  always @(posedge clk_i) begin : scoreboard
    reading_t got, want, pred;
    if (!rst_ni) begin
      reg_capacity    = '0;
      reg_threshold   = ThrW'(ThrReset);
      reg_rst_valid   = 1'b0;
      reg_rst_remain  = '0;
      reg_rst_cap     = '0;
      reg_rst_pct     = PctAbsent;
      est_remaining   = '0;
      est_last_used   = '0;
      est_rec_cap     = '0;
      est_start_lvl   = PctAbsent;
      est_ready       = 1'b0;
      est_start_check = 1'b1;
      est_cap_changed = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = rd(int'(percent_permille_o), int'(remaining_mah_o), did_reset_o, charge_seen_o);
        if (due_readings.size() == 0) begin
          note_fault($sformatf("unexpected reading: pct %0d rem %0d reset %0b seen %0b",
                               got.pct, got.rem, got.did_reset, got.seen));
        end else begin
          want = due_readings.pop_front();
          if (got.pct !== want.pct || got.rem !== want.rem ||
              got.did_reset !== want.did_reset || got.seen !== want.seen) begin
            note_fault($sformatf(
              "mismatch: expected pct %0d rem %0d reset %0b seen %0b, got %0d %0d %0b %0b",
              want.pct, want.rem, want.did_reset, want.seen,
              got.pct, got.rem, got.did_reset, got.seen));
          end else begin
            readings_ok++;
            refills  += want.did_reset;
            seen_cnt += want.seen;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CAPACITY:   reg_capacity   = cfg_data_i[MahW-1:0];
          CFG_THRESHOLD:  reg_threshold  = cfg_data_i[ThrW-1:0];
          CFG_RST_VALID:  reg_rst_valid  = cfg_data_i[0];
          CFG_RST_REMAIN: reg_rst_remain = cfg_data_i[MahW-1:0];
          CFG_RST_CAP:    reg_rst_cap    = cfg_data_i[MahW-1:0];
          CFG_RST_PCT:    reg_rst_pct    = int'($signed(cfg_data_i[PctW-1:0]));
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        words_in++;
        if (count_coulombs(ccg_op_e'(opcode_i), level_permille_i, used_mah_i, pred)) begin
          due_readings.push_back(typed_i ? typed_word : pred);
        end
      end
    end
  end

  // Offers one word and holds it until taken; a gap then drops valid for a while.
  task automatic send_word(input ccg_op_e op, input logic [LevelW-1:0] lvl,
                           input logic [UsedW-1:0] used, input bit typed,
                           input reading_t tw, input int unsigned gap);
    opcode_i         <= op;
    level_permille_i <= lvl;
    used_mah_i       <= used;
    typed_i          <= typed;
    typed_word       <= tw;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Lets every outstanding reading arrive and the sequencer fall idle. The first
  // edge makes sure the scoreboard has booked the last accepted word.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_readings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    writes_done++;
  endtask

  // The receiver stalls in stretches of its own; once it holds off for a long time.
  initial begin : stall_pattern
    stall_mode_e mode;
    int unsigned span;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        for (int unsigned k = 0; k < HoldOff; k++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
        squeeze_done = 1'b1;
      end else begin
        mode = stall_mode_e'($urandom_range(0, 3));
        span = $urandom_range(8, 80);
        repeat (span) begin
          case (mode)
            FLOW:    out_stall_i <= 1'b0;
            LIGHT:   out_stall_i <= ($urandom_range(0, 3) == 0);
            HALF:    out_stall_i <= 1'($urandom_range(0, 1));
            default: out_stall_i <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < Limit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("testbench failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent, burst_left, gap;
    int          lvl_trk, cap_pick, rcap, step, pick;
    logic [UsedW-1:0] used_trk;
    ccg_op_e     op;
    logic [LevelW-1:0] lvl;
    logic [UsedW-1:0]  used;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    opcode_i         = OP_SAMPLE;
    level_permille_i = '0;
    used_mah_i       = '0;
    typed_i          = 1'b0;
    typed_word       = '0;

    // Directed plan. Readings typed in by hand where they are obvious.
    // Zero capacity: the level passes through, saturated above full scale.
    add_item(OP_SAMPLE, 1023, 0, 1'b1, rd(1000, 0, 1'b0, 1'b0));
    add_item(OP_SAMPLE, 0, 24'hFFFFFF, 1'b1, rd(0, 0, 1'b0, 1'b0));
    add_item(OP_SPARE, 1023, 24'hFFFFFF);
    add_reg(CFG_CAPACITY, 1000);
    // Nothing restored, so the first sample fills; then the start-up check sees a rise.
    add_item(OP_SAMPLE, 500, 100, 1'b1, rd(500, 1000, 1'b1, 1'b0));
    add_item(OP_SAMPLE, 500, 100, 1'b1, rd(500, 1000, 1'b1, 1'b1));
    add_item(OP_SAMPLE, 520, 100);
    // Counter going down adds charge back; large swings clamp at both ends.
    add_item(OP_SAMPLE, 520, 50);
    add_item(OP_SAMPLE, 520, 24'hFFFFFF, 1'b1, rd(0, 0, 1'b0, 1'b0));
    add_item(OP_SAMPLE, 520, 0, 1'b1, rd(1000, 1000, 1'b0, 1'b0));
    add_item(OP_CAPCHG, 0, 0);
    add_item(OP_SAMPLE, 0, 5, 1'b1, rd(0, 1000, 1'b1, 1'b0));
    // Capacity tolerance: 101 mAh away refills, 100 mAh away does not.
    add_reg(CFG_CAPACITY, 1101);
    add_item(OP_SAMPLE, 0, 0, 1'b1, rd(0, 1101, 1'b1, 1'b0));
    add_reg(CFG_CAPACITY, 1001);
    add_item(OP_SAMPLE, 0, 0);
    // Restart from saved values with the widest threshold.
    add_reg(CFG_RST_VALID, 1);
    add_reg(CFG_RST_REMAIN, 300);
    add_reg(CFG_RST_CAP, 1000);
    add_reg(CFG_RST_PCT, 400);
    add_reg(CFG_THRESHOLD, 1000);
    add_reg(CFG_CAPACITY, 1000);
    add_item(OP_RESTART, 0, 0);
    add_item(OP_SAMPLE, 1000, 10);
    // Zero threshold with an absent start-up record: any level counts as charging.
    add_reg(CFG_THRESHOLD, 0);
    add_reg(CFG_RST_PCT, -10);
    add_item(OP_RESTART, 0, 0);
    add_item(OP_SAMPLE, 0, 0, 1'b1, rd(0, 1000, 1'b1, 1'b1));
    add_reg(CFG_RST_VALID, 0);
    add_item(OP_RESTART, 1023, 24'hFFFFFF);
    add_item(OP_SAMPLE, 10, 0, 1'b1, rd(10, 1000, 1'b1, 1'b0));
    // Largest capacity: a mismatch refill, a charging refill, then a counted sample.
    add_reg(CFG_CAPACITY, 20'hFFFFF);
    add_item(OP_SAMPLE, 1000, 0, 1'b1, rd(1000, 20'hFFFFF, 1'b1, 1'b0));
    add_item(OP_SAMPLE, 1000, 1, 1'b1, rd(1000, 20'hFFFFF, 1'b1, 1'b1));
    add_item(OP_SAMPLE, 1000, 1);
    // A restore with no capacity recorded skips the mismatch test.
    add_reg(CFG_RST_VALID, 1);
    add_reg(CFG_RST_CAP, 0);
    add_reg(CFG_RST_REMAIN, 20'hFFFFF);
    add_reg(CFG_RST_PCT, 1000);
    add_reg(CFG_THRESHOLD, 1000);
    add_item(OP_RESTART, 0, 0);
    add_item(OP_SAMPLE, 1000, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_word(plan[i].op, plan[i].lvl, plan[i].used, plan[i].typed, plan[i].want,
                  $urandom_range(0, 3));
      end
    end

    // Random phases: a fresh register setting each, then mostly plausible telemetry.
    lvl_trk  = 500;
    used_trk = '0;
    for (int unsigned ph = 0; ph < Phases; ph++) begin
      settle();
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        cap_pick = 0;
      end else if (pick == 1) begin
        cap_pick = 20'hFFFFF;
      end else if (pick == 2) begin
        cap_pick = $urandom_range(0, 20'hFFFFF);
      end else begin
        cap_pick = $urandom_range(1, 5000);
      end
      write_reg(CFG_CAPACITY, CfgDataW'(cap_pick));
      pick = $urandom_range(0, 4);
      write_reg(CFG_THRESHOLD,
                CfgDataW'((pick == 0) ? 0 : (pick == 1) ? 1000 : $urandom_range(0, 1000)));
      write_reg(CFG_RST_VALID, CfgDataW'($urandom_range(0, 3) != 0));
      pick = $urandom_range(0, 9);
      write_reg(CFG_RST_REMAIN, CfgDataW'((pick == 0) ? 20'hFFFFF :
                                          (pick < 3) ? $urandom_range(0, 20'hFFFFF) :
                                          $urandom_range(0, cap_pick + 100)));
      pick = $urandom_range(0, 5);
      if (pick == 0) begin
        rcap = cap_pick;
      end else if (pick == 1) begin
        rcap = 0;
      end else if (pick < 4) begin
        rcap = cap_pick + int'($urandom_range(0, 300)) - 150;
        rcap = (rcap < 0) ? 0 : (rcap > 20'hFFFFF) ? 20'hFFFFF : rcap;
      end else begin
        rcap = $urandom_range(0, 20'hFFFFF);
      end
      write_reg(CFG_RST_CAP, CfgDataW'(rcap));
      pick = $urandom_range(0, 4);
      write_reg(CFG_RST_PCT, CfgDataW'((pick == 0) ? PctAbsent : (pick == 1) ? 1000 :
                                       int'($urandom_range(0, 1010)) - 10));
      if (ph % 3 == 0) begin
        write_reg((ph % 2 == 0) ? IdxPastEnd : IdxTop, CfgDataW'($urandom));
      end
      if (ph == SqueezePhase) begin
        squeeze_req = 1'b1;
      end
      if ($urandom_range(0, 1) != 0) begin
        send_word(OP_RESTART, LevelW'($urandom), UsedW'($urandom), 1'b0, '0, 0);
      end

      step       = cap_pick / 50 + 3;
      sent       = 0;
      burst_left = 0;
      while (sent < PhaseItems) begin
        pick = $urandom_range(0, 99);
        lvl  = LevelW'($urandom);
        used = UsedW'($urandom);
        if (pick < 3) begin
          op = OP_RESTART;
        end else if (pick < 6) begin
          op = OP_CAPCHG;
        end else if (pick < 9) begin
          op = OP_SPARE;
        end else if (pick < 16) begin
          op = OP_SAMPLE;
        end else begin
          // Plausible telemetry: the level drifts, the counter creeps upwards.
          op      = OP_SAMPLE;
          lvl_trk = lvl_trk + int'($urandom_range(0, 8)) - 5;
          if ($urandom_range(0, 24) == 0) begin
            lvl_trk += $urandom_range(0, 400);
          end
          lvl_trk = (lvl_trk < 0) ? 0 : (lvl_trk > 1000) ? 1000 : lvl_trk;
          if ($urandom_range(0, 32) == 0) begin
            used_trk -= UsedW'($urandom_range(0, step));
          end else begin
            used_trk += UsedW'($urandom_range(0, step));
          end
          lvl  = LevelW'(lvl_trk);
          used = used_trk;
        end
        if (ph % 4 == 0 || ph == SqueezePhase) begin
          gap = 0;
        end else if (burst_left == 0) begin
          gap        = $urandom_range(1, 12);
          burst_left = $urandom_range(1, 24);
        end else begin
          gap = 0;
          burst_left--;
        end
        send_word(op, lvl, used, 1'b0, '0, gap);
        if (op != OP_SPARE) begin
          sent++;
        end
      end
    end

    settle();
    if (due_readings.size() != 0) begin
      note_fault($sformatf("%0d readings never arrived", due_readings.size()));
    end
    $display("Run covered %0d input words and %0d register writes in %0d cycles.",
             words_in, writes_done, cycle_cnt);
    $display("Readings matched: %0d, of which %0d full refills and %0d with charging seen.",
             readings_ok, refills, seen_cnt);
    if (fail_cnt != 0) begin
      $display("%0d faults found", fail_cnt);
    end
    if (fail_cnt == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ccg_pkg.sv
rtl/ccg_cfg.sv
rtl/ccg_div.sv
rtl/coulomb_count_charge_gauge.sv
verif/testbench.sv
